FILE: rtl/tmn_pkg.sv
// Shared types and constants for the trimmed-mean ADC normalizer.
package tmn_pkg;

	localparam int CH_W        = 3;
	localparam int SAMPLE_W    = 12;
	localparam int SUM_W       = 18;
	localparam int CNT_W       = 7;
	localparam int PCT_W       = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - PCT_W;
	localparam int DIV_W       = 27;
	localparam int DIV_CNT_W   = 5;
	localparam int NUM_REGS    = 7;
	localparam int FS_LOW_REGS = 4;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 12'hFFF;
	localparam logic [SAMPLE_W-1:0] FS_DEFAULT_LOW  = 12'd3660;
	localparam logic [SAMPLE_W-1:0] FS_DEFAULT_HIGH = 12'd3650;
	localparam logic [DIV_W-1:0]    PCT_MUL         = 27'd25600;
	localparam logic [PCT_W-1:0]    Q16_MAX         = 16'hFFFF;

	typedef struct packed {
		logic [CNT_W-1:0]    count;
		logic [SAMPLE_W-1:0] max;
		logic [SAMPLE_W-1:0] min;
		logic [SUM_W-1:0]    sum;
	} acc_rec_t;

	localparam acc_rec_t ACC_RESET = '{
		count: '0,
		max:   '0,
		min:   SAMPLE_MAX,
		sum:   '0
	};

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MEAN,
		ST_MULT,
		ST_SCALE_GO,
		ST_SCALE_DIV,
		ST_RESULT
	} state_t;

endpackage

FILE: rtl/tmn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tmn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/tmn_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tmn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tmn_pkg::div_req_t req,
	output tmn_pkg::div_rsp_t rsp
);
	import tmn_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [SAMPLE_W-1:0]  divisor_q;
	logic [DIV_W-1:0]     quo_q;
	logic [SAMPLE_W:0]    trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= SAMPLE_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[SAMPLE_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: rtl/trimmed_mean_adc_normalizer.sv
// Top level of the trimmed-mean ADC normalizer: accumulator store, sequencer, output register.
//
// Input transfers on s_axis carry one converter sample (tdata) tagged with its channel (tuser).
// Per channel the block accumulates sum, minimum, maximum and count in a small RAM; the
// record is read in the accept cycle and written back in the next one.
// A sample that is not the SAMPLES-th of its channel is written back in UPDATE and the block returns to IDLE.
// The SAMPLES-th sample closes the channel: the record is cleared, the trimmed mean comes
// from a reciprocal multiply, and its Q8.8 percentage of the channel's full scale goes
// through a 27-step serial divider. The result is loaded into the output register in the
// RESULT state, once that register is free, and the next sample is accepted after the block
// returns to IDLE. A channel number of CHANNELS or more is dropped in its accept cycle.
// Results leave on m_axis: tdata holds trimmed_mean and percent_q8, tuser the channel.
// While a result waits for m_axis_tready the block keeps accepting samples; a closing
// sample then stalls only at the point where its own result must be loaded.
// Full-scale registers must be written through cfg_* while the block is idle (not enforced).
// Reset clears every channel's accumulators at once through per-entry valid bits and
// restores the full-scale registers to their defaults; no clearing pass is needed.
module trimmed_mean_adc_normalizer #(
	parameter int CHANNELS = 7,
	parameter int SAMPLES  = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tmn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [11:0] sample, [15:12] zero
	input  logic [tmn_pkg::CH_W-1:0]         s_axis_tuser,  // [2:0] channel
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tmn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [11:0] trimmed_mean, [27:12] percent_q8, [31:28] zero
	output logic [tmn_pkg::CH_W-1:0]         m_axis_tuser,  // [2:0] out_channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmn_pkg::CH_W-1:0]         cfg_index,
	input  logic [tmn_pkg::SAMPLE_W-1:0]     cfg_data
);
	import tmn_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REC_W = $bits(acc_rec_t);
	localparam int MEAN_DIV   = SAMPLES - 2;
	localparam int MEAN_SHIFT = SUM_W + $clog2(MEAN_DIV);
	localparam int RECIP_W    = SUM_W + 2;
	localparam int MPROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(((longint'(1) << MEAN_SHIFT)
		+ longint'(MEAN_DIV) - longint'(1)) / longint'(MEAN_DIV));

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] fs_q [NUM_REGS];
	logic [CHANNELS-1:0] valid_q;
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] scale_q;
	logic [SUM_W-1:0]    trim_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [DIV_W-1:0]    prod_q;
	logic [PCT_W-1:0]    pct_q;
	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [SAMPLE_W-1:0] out_mean_q;
	logic [PCT_W-1:0]    out_pct_q;

	logic        accept;
	logic        ch_ok;
	logic        ram_we;
	logic        out_load;
	logic        finish;
	logic [REC_W-1:0] ram_rd_data;
	acc_rec_t    cur_rec;
	acc_rec_t    new_rec;
	acc_rec_t    wr_rec;
	logic [SUM_W-1:0] trim;
	logic [MPROD_W-1:0] mean_prod;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign ch_ok     = {1'b0, s_axis_tuser} < (CH_W + 1)'(CHANNELS);

	// Read-modify-write of the channel record
	assign cur_rec = valid_q[ch_q[AW-1:0]] ? acc_rec_t'(ram_rd_data) : ACC_RESET;

	always_comb begin
		new_rec.sum   = cur_rec.sum + SUM_W'(sample_q);
		new_rec.min   = (sample_q <= cur_rec.min) ? sample_q : cur_rec.min;
		new_rec.max   = (sample_q >= cur_rec.max) ? sample_q : cur_rec.max;
		new_rec.count = cur_rec.count + CNT_W'(1);
	end

	assign finish = new_rec.count == CNT_W'(SAMPLES);
	assign trim   = new_rec.sum - SUM_W'(new_rec.min) - SUM_W'(new_rec.max);
	assign wr_rec = finish ? ACC_RESET : new_rec;

	// Divide the trimmed sum by SAMPLES-2 through its reciprocal
	assign mean_prod = MPROD_W'(trim_q) * MPROD_W'(MEAN_RECIP);

	tmn_ram #(
		.WIDTH(REC_W),
		.DEPTH(CHANNELS)
	) u_acc_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ch_q[AW-1:0]),
		.wr_data(wr_rec),
		.rd_en  (accept),
		.rd_addr(s_axis_tuser[AW-1:0]),
		.rd_data(ram_rd_data)
	);

	tmn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && ch_ok) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = finish ? ST_MEAN : ST_IDLE;
			end
			ST_MEAN: begin
				state_d = ST_MULT;
			end
			ST_MULT: begin
				state_d = ST_SCALE_GO;
			end
			ST_SCALE_GO: begin
				state_d = ST_SCALE_DIV;
			end
			ST_SCALE_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_axis_tready    = 1'b0;
		ram_we           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = scale_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_UPDATE: begin
				ram_we = 1'b1;
			end
			ST_SCALE_GO: begin
				div_req.start = 1'b1;
			end
			ST_RESULT: begin
				out_load = !out_valid_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				fs_q[i] <= (i < FS_LOW_REGS) ? FS_DEFAULT_LOW : FS_DEFAULT_HIGH;
			end
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[ch_q[AW-1:0]] <= 1'b1;
			end
			if (cfg_valid && cfg_ready && ({1'b0, cfg_index} < (CH_W + 1)'(NUM_REGS))) begin
				fs_q[cfg_index] <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= s_axis_tuser;
			sample_q <= s_axis_tdata[SAMPLE_W-1:0];
		end
		if (state_q == ST_UPDATE) begin
			scale_q <= ({1'b0, ch_q} < (CH_W + 1)'(NUM_REGS)) ? fs_q[ch_q] : FS_DEFAULT_HIGH;
			trim_q  <= trim;
		end
		if (state_q == ST_MEAN) begin
			mean_q <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
		end
		if (state_q == ST_MULT) begin
			prod_q <= DIV_W'(mean_q) * PCT_MUL;
		end
		if (state_q == ST_SCALE_DIV && div_rsp.done) begin
			pct_q <= (div_rsp.quotient[DIV_W-1:PCT_W] != '0) ? Q16_MAX
				: div_rsp.quotient[PCT_W-1:0];
		end
		if (out_load) begin
			out_ch_q   <= ch_q;
			out_mean_q <= mean_q;
			out_pct_q  <= pct_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_pct_q, out_mean_q};
	assign m_axis_tuser  = out_ch_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_SCALE_DIV))
		else $error("divider finished outside its wait state");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(ch_q[AW-1:0])])
		else $error("written record not marked valid");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("output register overwritten before transfer");

	a_closing_to_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && finish) |=> (state_q == ST_MEAN && !s_axis_tready))
		else $error("closing sample did not advance to the mean stage");

endmodule
